// ===== hdl/tolerant_key_cache_fifo_evict_defines.svh =====
// ----------------------------------------------------------------------------
// tolerant key cache assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef TOLERANT_KEY_CACHE_FIFO_EVICT_DEFINES_SVH
`define TOLERANT_KEY_CACHE_FIFO_EVICT_DEFINES_SVH

// same-cycle implication
`define TKC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tkc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_pkg
// shared widths, codes and types of the tolerant key cache
// ----------------------------------------------------------------------------
package tkc_pkg;

    localparam int Z_W    = 7;
    localparam int A_W    = 9;
    localparam int E_W    = 32;
    localparam int TOL_W  = 16;
    localparam int SLOT_W = 3;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1000;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 1'd0;

    typedef struct packed {
        logic [Z_W-1:0] protons;
        logic [A_W-1:0] nucleons;
        logic [E_W-1:0] energy;
    } t_entry;

endpackage

// ===== hdl/tkc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_if
// request and response channels of the tolerant key cache
// ----------------------------------------------------------------------------
interface tkc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [tkc_pkg::Z_W-1:0]    proton_number;
    logic [tkc_pkg::A_W-1:0]    mass_number;
    logic [tkc_pkg::E_W-1:0]    excitation_energy;
    logic [tkc_pkg::SLOT_W-1:0] target_slot;

    modport source (
        output valid, operation, proton_number, mass_number, excitation_energy,
               target_slot,
        input  ready
    );
    modport sink (
        input  valid, operation, proton_number, mass_number, excitation_energy,
               target_slot,
        output ready
    );
endinterface

interface tkc_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [tkc_pkg::SLOT_W-1:0] slot;
    logic                      hit;
    logic                      evicted;
    logic                      removed;

    modport source (
        output valid, slot, hit, evicted, removed,
        input  ready
    );
    modport sink (
        input  valid, slot, hit, evicted, removed,
        output ready
    );
endinterface

// ===== hdl/tkc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_cfg
// apb register file holding the energy match tolerance
// ----------------------------------------------------------------------------
module tkc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tkc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tkc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tkc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [tkc_pkg::TOL_W-1:0]         o_tolerance
);

    logic [tkc_pkg::TOL_W-1:0]     r_tolerance;
    logic [tkc_pkg::REG_IDX_W-1:0] w_reg_idx;

    assign w_reg_idx   = paddr[tkc_pkg::APB_ADDR_W-1:2];
    assign pready      = 1'b1;
    assign o_tolerance = r_tolerance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= tkc_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (w_reg_idx == tkc_pkg::REG_TOLERANCE)) begin
            r_tolerance <= pwdata[tkc_pkg::TOL_W-1:0];
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            tkc_pkg::REG_TOLERANCE: begin
                prdata = {{(tkc_pkg::APB_DATA_W - tkc_pkg::TOL_W){1'b0}}, r_tolerance};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// ===== hdl/tkc_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkc_mem
// key store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tkc_mem #(
    parameter int NUM_ENTRIES = 8,
    parameter int IDX_W       = 3
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  tkc_pkg::t_entry      i_wr_data,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output tkc_pkg::t_entry      o_rd_data
);

    tkc_pkg::t_entry r_mem [NUM_ENTRIES];
    tkc_pkg::t_entry r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== hdl/tkc_engine.sv =====
`timescale 1ns / 1ps
`include "tolerant_key_cache_fifo_evict_defines.svh"
// ----------------------------------------------------------------------------
// tkc_engine
// scan sequencer: reads every slot, compares, decides and writes back
// ----------------------------------------------------------------------------
module tkc_engine #(
    parameter int NUM_ENTRIES = 8,
    parameter int IDX_W       = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tkc_pkg::TOL_W-1:0]  i_tolerance,
    tkc_req_if.sink                    i_req,
    tkc_rsp_if.source                  o_rsp,
    output logic                       o_wr_en,
    output logic [IDX_W-1:0]           o_wr_addr,
    output tkc_pkg::t_entry            o_wr_data,
    output logic [IDX_W-1:0]           o_rd_addr,
    input  tkc_pkg::t_entry            i_rd_data
);

    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                   r_state;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_cmp_vld;
    logic [IDX_W-1:0]             r_cmp_idx;
    logic [NUM_ENTRIES-1:0]       r_valid;
    logic [IDX_W-1:0]             r_oldest;

    logic                         r_op;
    tkc_pkg::t_entry              r_key;
    logic [tkc_pkg::SLOT_W-1:0]   r_tgt;
    logic [IDX_W-1:0]             r_tgt_idx;
    logic                         r_tgt_ok;

    logic                         r_found;
    logic [IDX_W-1:0]             r_found_idx;
    logic                         r_free_ok;
    logic [IDX_W-1:0]             r_free_idx;
    logic                         r_other_ok;
    logic [IDX_W-1:0]             r_other_idx;

    logic                         r_out_vld;
    logic [tkc_pkg::SLOT_W-1:0]   r_slot;
    logic                         r_hit;
    logic                         r_evict;
    logic                         r_removed;

    logic                         w_accept;
    logic                         w_leave;
    logic                         w_cmp_valid;
    logic [tkc_pkg::E_W-1:0]      w_diff;
    logic                         w_match;
    logic [IDX_W-1:0]             w_ins_idx;
    logic [IDX_W-1:0]             w_oldest_inc;
    logic                         w_rm;
    logic                         w_insert;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_leave     = (r_state == ST_DONE) && (!r_out_vld || o_rsp.ready);

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.slot    = r_slot;
    assign o_rsp.hit     = r_hit;
    assign o_rsp.evicted = r_evict;
    assign o_rsp.removed = r_removed;

    assign o_rd_addr = (r_cnt < LAST) ? r_cnt[IDX_W-1:0] : '0;

    // compare stage on the registered read data
    assign w_cmp_valid = r_valid[r_cmp_idx];
    assign w_diff      = (r_key.energy >= i_rd_data.energy) ?
                         (r_key.energy - i_rd_data.energy) :
                         (i_rd_data.energy - r_key.energy);
    assign w_match     = (i_rd_data.protons == r_key.protons) &&
                         (i_rd_data.nucleons == r_key.nucleons) &&
                         (w_diff < {{(tkc_pkg::E_W - tkc_pkg::TOL_W){1'b0}}, i_tolerance});

    // decision
    assign w_ins_idx    = r_free_ok ? r_free_idx : r_oldest;
    assign w_oldest_inc = ((CNT_W'(r_oldest) + CNT_W'(1)) == LAST) ? '0 :
                          (r_oldest + IDX_W'(1));
    assign w_rm         = r_tgt_ok && r_valid[r_tgt_idx];
    assign w_insert     = (r_op == tkc_pkg::OP_FIND) && !r_found;

    assign o_wr_en   = w_leave && w_insert;
    assign o_wr_addr = w_ins_idx;
    assign o_wr_data = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= '0;
            r_oldest  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == ST_SCAN) && (r_cnt != LAST);
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_leave) begin
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                        if (w_insert) begin
                            r_valid[w_ins_idx] <= 1'b1;
                            if (!r_free_ok) begin
                                r_oldest <= w_oldest_inc;
                            end
                        end else if ((r_op == tkc_pkg::OP_REMOVE) && w_rm) begin
                            r_valid[r_tgt_idx] <= 1'b0;
                            if ((r_tgt_idx == r_oldest) && r_other_ok) begin
                                r_oldest <= r_other_idx;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= o_rd_addr;
        if (w_accept) begin
            r_op           <= i_req.operation;
            r_key.protons  <= i_req.proton_number;
            r_key.nucleons <= i_req.mass_number;
            r_key.energy   <= i_req.excitation_energy;
            r_tgt          <= i_req.target_slot;
            r_tgt_idx      <= IDX_W'(i_req.target_slot);
            r_tgt_ok       <= (32'(i_req.target_slot) < NUM_ENTRIES);
            r_found        <= 1'b0;
            r_free_ok      <= 1'b0;
            r_other_ok     <= 1'b0;
        end else if (r_cmp_vld) begin
            if (w_cmp_valid) begin
                if (!r_found && w_match) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_cmp_idx;
                end
                if (!r_other_ok && (r_cmp_idx != r_tgt_idx)) begin
                    r_other_ok  <= 1'b1;
                    r_other_idx <= r_cmp_idx;
                end
            end else begin
                // last free slot seen is the highest
                r_free_ok  <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
        if (w_leave) begin
            if (r_op == tkc_pkg::OP_REMOVE) begin
                r_slot <= r_tgt;
            end else if (r_found) begin
                r_slot <= tkc_pkg::SLOT_W'(r_found_idx);
            end else begin
                r_slot <= tkc_pkg::SLOT_W'(w_ins_idx);
            end
            r_hit     <= (r_op == tkc_pkg::OP_FIND) && r_found;
            r_evict   <= w_insert && !r_free_ok;
            r_removed <= (r_op == tkc_pkg::OP_REMOVE) && w_rm;
        end
    end

    `TKC_ASSERT_NEXT(a_accept_starts_scan, w_accept, (r_state == ST_SCAN) && (r_cnt == '0), "accepted word did not start a scan")
    `TKC_ASSERT_NEXT(a_result_only_from_done, !r_out_vld && (r_state != ST_DONE), !r_out_vld, "result appeared without a decision")
    `TKC_ASSERT_NOW(a_result_flags_exclusive, r_out_vld, !(r_hit && r_evict) && !(r_removed && (r_hit || r_evict)), "conflicting result flags")
    `TKC_ASSERT_NOW(a_evict_only_when_full, (r_state == ST_DONE) && w_insert && !r_free_ok, &r_valid, "eviction while a slot is free")

endmodule

// ===== hdl/tolerant_key_cache_fifo_evict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerant_key_cache_fifo_evict
// fully associative nuclide key cache with tolerant energy match
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request word: find-or-insert a key, or remove a slot.
//   o_rsp returns exactly one word per request: slot, hit, evicted, removed.
//   the apb port holds the energy tolerance at byte address 0, reset 1000.
// scan order
//   a request reads each slot of the key memory in turn, compares each
//   registered read word against the key, then decides and writes back.
//   one request is in flight at a time; the next is accepted in the cycle
//   after the decision.
// reset
//   all slots invalid, oldest pointer at slot 0, tolerance 1000.
//   key memory contents are not cleared; invalid slots are never matched.
// stall
//   a result waits in the output register while o_rsp.ready is low; a new
//   request is still taken and scanned, then holds at its decision until
//   the output register is free.
// ----------------------------------------------------------------------------
module tolerant_key_cache_fifo_evict #(
    parameter int NUM_ENTRIES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tkc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tkc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tkc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    tkc_req_if.sink                           i_req,
    tkc_rsp_if.source                         o_rsp
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [tkc_pkg::TOL_W-1:0] w_tolerance;
    logic                      w_wr_en;
    logic [IDX_W-1:0]          w_wr_addr;
    tkc_pkg::t_entry           w_wr_data;
    logic [IDX_W-1:0]          w_rd_addr;
    tkc_pkg::t_entry           w_rd_data;

    tkc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tolerance (w_tolerance)
    );

    tkc_mem #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tkc_engine #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tolerance (w_tolerance),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the tolerant key cache word by word against an in-house predictor;
// directed keys first, then random phases over several tolerances and idle
// patterns on both channels, with tolerance writes only while the cache is idle
// ----------------------------------------------------------------------------
module testbench;
    import tkc_pkg::*;

    localparam int NUM_SLOTS = 8;

    typedef struct packed {
        logic              operation;
        logic [Z_W-1:0]    protons;
        logic [A_W-1:0]    nucleons;
        logic [E_W-1:0]    energy;
        logic [SLOT_W-1:0] target;
    } cache_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              evicted;
        logic              removed;
    } cache_rsp_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tkc_req_if req_if ();
    tkc_rsp_if rsp_if ();

    tolerant_key_cache_fifo_evict u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predictor state
    logic              slot_valid   [NUM_SLOTS];
    logic [Z_W-1:0]    slot_protons [NUM_SLOTS];
    logic [A_W-1:0]    slot_nucleons[NUM_SLOTS];
    logic [E_W-1:0]    slot_energy  [NUM_SLOTS];
    logic [SLOT_W-1:0] oldest_slot;
    logic [TOL_W-1:0]  tolerance;

    cache_req_t request_q[$];
    cache_rsp_t lookup_results_q[$];
    cache_req_t key_pool[$];
    cache_req_t driven_req;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;

    function automatic cache_req_t find_req(input logic [Z_W-1:0] z, input logic [A_W-1:0] a,
                                            input logic [E_W-1:0] e);
        cache_req_t r;
        r.operation = OP_FIND;
        r.protons   = z;
        r.nucleons  = a;
        r.energy    = e;
        r.target    = SLOT_W'($urandom);
        return r;
    endfunction

    function automatic cache_req_t remove_req(input logic [SLOT_W-1:0] s);
        cache_req_t r;
        r.operation = OP_REMOVE;
        r.protons   = Z_W'($urandom);
        r.nucleons  = A_W'($urandom);
        r.energy    = $urandom;
        r.target    = s;
        return r;
    endfunction

    function automatic cache_rsp_t cache_access(input cache_req_t r);
        cache_rsp_t        res;
        bit                found;
        bit                have_free;
        logic [SLOT_W-1:0] free_slot;
        logic [E_W-1:0]    diff;
        res       = '0;
        found     = 1'b0;
        have_free = 1'b0;
        free_slot = '0;
        if (r.operation == OP_FIND) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_valid[i]) begin
                    diff = (r.energy >= slot_energy[i]) ? r.energy - slot_energy[i]
                                                        : slot_energy[i] - r.energy;
                    if (!found && slot_protons[i] == r.protons &&
                        slot_nucleons[i] == r.nucleons && diff < tolerance) begin
                        found    = 1'b1;
                        res.slot = SLOT_W'(i);
                    end
                end else begin
                    have_free = 1'b1;
                    free_slot = SLOT_W'(i);
                end
            end
            if (found) begin
                res.hit = 1'b1;
            end else begin
                if (have_free) begin
                    res.slot = free_slot;
                end else begin
                    res.slot    = oldest_slot;
                    res.evicted = 1'b1;
                    oldest_slot = (oldest_slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : oldest_slot + 1'b1;
                end
                slot_valid[res.slot]    = 1'b1;
                slot_protons[res.slot]  = r.protons;
                slot_nucleons[res.slot] = r.nucleons;
                slot_energy[res.slot]   = r.energy;
            end
        end else begin
            res.slot = r.target;
            if (slot_valid[r.target]) begin
                slot_valid[r.target] = 1'b0;
                res.removed          = 1'b1;
                if (r.target == oldest_slot) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!found && slot_valid[i]) begin
                            found       = 1'b1;
                            oldest_slot = SLOT_W'(i);
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOLERANCE, 2'b00};
        pwdata  <= {{(APB_DATA_W - TOL_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        tolerance = value;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (request_q.size() != 0 || req_if.valid || lookup_results_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 57;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 57;
            end
            default: begin
                send_idle_pct  = 14;
                recv_stall_pct = 14;
            end
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        cache_req_t nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                lookup_results_q.push_back(cache_access(driven_req));
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = request_q.pop_front();
                    driven_req                <= nxt;
                    req_if.valid              <= 1'b1;
                    req_if.operation          <= nxt.operation;
                    req_if.proton_number      <= nxt.protons;
                    req_if.mass_number        <= nxt.nucleons;
                    req_if.excitation_energy  <= nxt.energy;
                    req_if.target_slot        <= nxt.target;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        cache_rsp_t want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (lookup_results_q.size() == 0) begin
                    report_mismatch("response word with nothing outstanding");
                end else begin
                    want = lookup_results_q.pop_front();
                    if (rsp_if.slot !== want.slot)
                        report_mismatch($sformatf("slot got %0d want %0d", rsp_if.slot,
                                                  want.slot));
                    if (rsp_if.hit !== want.hit)
                        report_mismatch($sformatf("hit got %0b want %0b", rsp_if.hit, want.hit));
                    if (rsp_if.evicted !== want.evicted)
                        report_mismatch($sformatf("evicted got %0b want %0b", rsp_if.evicted,
                                                  want.evicted));
                    if (rsp_if.removed !== want.removed)
                        report_mismatch($sformatf("removed got %0b want %0b", rsp_if.removed,
                                                  want.removed));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [TOL_W-1:0] phase_tol [6];
        cache_req_t       key;
        int unsigned      pick;
        int unsigned      tol_i;
        logic [E_W-1:0]   delta;
        logic [Z_W-1:0]   z;
        logic [A_W-1:0]   a;
        logic [E_W-1:0]   e;

        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        req_if.valid             = 1'b0;
        req_if.operation         = OP_FIND;
        req_if.proton_number     = '0;
        req_if.mass_number       = '0;
        req_if.excitation_energy = '0;
        req_if.target_slot       = '0;
        rsp_if.ready             = 1'b0;
        driven_req               = '0;
        mismatch_count           = 0;
        tolerance                = TOL_RESET;
        oldest_slot              = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid[i]    = 1'b0;
            slot_protons[i]  = '0;
            slot_nucleons[i] = '0;
            slot_energy[i]   = '0;
        end
        set_idle(0);

        // field extremes, tolerance edge, fill, eviction, removes
        request_q.push_back(find_req('0, '0, '0));
        request_q.push_back(find_req('1, '1, '1));
        request_q.push_back(find_req('0, '0, 32'd999));
        request_q.push_back(find_req('0, '0, 32'd1000));
        request_q.push_back(find_req('1, '1, '0));
        request_q.push_back(find_req('1, '1, 32'hFFFF_FC19));
        request_q.push_back(find_req(7'd1, 9'd2, 32'h5555_5555));
        request_q.push_back(find_req(7'd42, 9'd170, 32'hAAAA_AAAA));
        request_q.push_back(find_req(7'd85, 9'd341, 32'h0001_0000));
        request_q.push_back(find_req(7'd3, 9'd4, 32'h8000_0000));
        request_q.push_back(find_req(7'd64, 9'd256, 32'h1234_5678));
        request_q.push_back(remove_req(3'd1));
        request_q.push_back(remove_req(3'd1));
        for (int s = 0; s < NUM_SLOTS; s++) begin
            request_q.push_back(remove_req(SLOT_W'(s)));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // no window at all
        write_tolerance('0);
        request_q.push_back(find_req(7'd9, 9'd9, 32'd7));
        request_q.push_back(find_req(7'd9, 9'd9, 32'd7));
        wait_drained();

        // widest window
        write_tolerance('1);
        request_q.push_back(find_req(7'd5, 9'd5, 32'd0));
        request_q.push_back(find_req(7'd5, 9'd5, 32'd65534));
        request_q.push_back(find_req(7'd5, 9'd5, 32'd65535));
        wait_drained();

        phase_tol[0] = TOL_RESET;
        phase_tol[1] = '1;
        phase_tol[2] = '0;
        phase_tol[3] = 16'd1;
        phase_tol[4] = TOL_W'($urandom_range(3000, 2));
        phase_tol[5] = TOL_W'($urandom_range(65534, 3001));

        for (int p = 0; p < 6; p++) begin
            write_tolerance(phase_tol[p]);
            set_idle(p % 4);
            tol_i = phase_tol[p];
            for (int n = 0; n < 125; n++) begin
                pick = $urandom_range(99);
                if (pick < 20) begin
                    request_q.push_back(remove_req(SLOT_W'($urandom_range(NUM_SLOTS - 1))));
                end else if (pick < 65 && key_pool.size() != 0) begin
                    // revisit a known key with its energy nudged around the window
                    key   = key_pool[$urandom_range(key_pool.size() - 1)];
                    delta = $urandom_range(2 * tol_i + 2);
                    if ($urandom_range(1))
                        key.energy = (key.energy > '1 - delta) ? '1 : key.energy + delta;
                    else
                        key.energy = (key.energy < delta) ? '0 : key.energy - delta;
                    request_q.push_back(key);
                end else begin
                    if ($urandom_range(1)) begin
                        z = Z_W'($urandom_range(3));
                        a = A_W'($urandom_range(3));
                    end else begin
                        z = Z_W'($urandom);
                        a = A_W'($urandom);
                    end
                    case ($urandom_range(3))
                        0: e = $urandom_range(255);
                        1: e = '1 - $urandom_range(255);
                        default: e = $urandom;
                    endcase
                    key = find_req(z, a, e);
                    request_q.push_back(key);
                    key_pool.push_back(key);
                    if (key_pool.size() > 12) begin
                        void'(key_pool.pop_front());
                    end
                end
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
